// File: hdl/max_clique_size_search_assert.svh
// Assertion macros for the file that checks the search logic.
// Clock and reset are clk and rst_n; checks are off while reset is held.
`ifndef MAX_CLIQUE_SIZE_SEARCH_ASSERT_SVH
`define MAX_CLIQUE_SIZE_SEARCH_ASSERT_SVH

// Flag a condition that must never be seen at a clock edge.
`define MCSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Require a consequence in the cycle after an antecedent.
`define MCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/mcss_pkg.sv
package mcss_pkg;

  // Graph size and field widths
  localparam int MAX_VERTICES = 32;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int MASK_W       = 32;
  localparam int SIZE_W       = 6;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TEST,
    ST_EXPAND,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic row_wr;
    logic start;
    logic load;
    logic pop;
    logic expand;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic prune;
    logic at_root;
  } sts_t;

  // Count set bits of a candidate mask
  function automatic logic [SIZE_W-1:0] popcount(input logic [MASK_W-1:0] x);
    logic [SIZE_W-1:0] c;
    c = '0;
    for (int i = 0; i < MASK_W; i++) begin
      c = c + SIZE_W'(x[i]);
    end
    return c;
  endfunction

endpackage

// File: hdl/mcss_ctrl.sv
module mcss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mcss_pkg::sts_t sts,
  output mcss_pkg::cmd_t cmd
);
  import mcss_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_last) state_nxt = ST_TEST;
      end
      ST_LOAD: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (!sts.prune)       state_nxt = ST_EXPAND;
        else if (sts.at_root) state_nxt = ST_DONE;
        else                  state_nxt = ST_LOAD;
      end
      ST_EXPAND: begin
        state_nxt = ST_TEST;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands and input stall
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.row_wr = in_valid;
        cmd.start  = in_valid && in_last;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_TEST: begin
        cmd.pop = sts.prune && !sts.at_root;
      end
      ST_EXPAND: begin
        cmd.expand = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)             out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/mcss_dpath.sv
module mcss_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcss_pkg::cmd_t              cmd,
  output mcss_pkg::sts_t              sts,
  input  logic [mcss_pkg::VTX_W-1:0]  in_vertex,
  input  logic [mcss_pkg::MASK_W-1:0] in_neighbours,
  input  logic [mcss_pkg::MASK_W-1:0] in_candidates,
  output logic [mcss_pkg::SIZE_W-1:0] out_clique_size
);
  import mcss_pkg::*;

  // Adjacency rows with per-row valid bits; an unwritten row reads as zero
  logic [MASK_W-1:0]       adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_vld_r;

  // Candidate stack, one mask per depth
  logic [MASK_W-1:0] stk_r [MAX_VERTICES];

  logic [VTX_W-1:0]  cs_r;
  logic [SIZE_W-1:0] best_r;
  logic [MASK_W-1:0] p_r;
  logic [SIZE_W-1:0] size_r;

  logic [SIZE_W-1:0] bound;
  logic [MASK_W-1:0] low_bit;
  logic [MASK_W-1:0] p_rest;
  logic [MASK_W-1:0] row;
  logic [MASK_W-1:0] next_cand;
  logic [SIZE_W-1:0] deeper;
  logic              descend;

  // Prune test: current depth plus remaining candidates against best
  assign bound       = {1'b0, cs_r} + popcount(p_r);
  assign sts.prune   = (p_r == '0) || (bound <= best_r);
  assign sts.at_root = (cs_r == '0);

  // Branch on the lowest candidate
  assign low_bit = p_r & (~p_r + 1'b1);
  assign p_rest  = p_r & (p_r - 1'b1);

  // Select the chosen vertex's row
  always_comb begin
    row = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (low_bit[j] && adj_vld_r[j]) row = row | adj_r[j];
    end
  end

  assign next_cand = p_rest & row;
  assign deeper    = {1'b0, cs_r} + SIZE_W'(1);
  assign descend   = (next_cand != '0) && (deeper < SIZE_W'(MAX_VERTICES));

  // Write adjacency rows
  always_ff @(posedge clk) begin
    if (cmd.row_wr) adj_r[in_vertex] <= in_neighbours;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_vld_r <= '0;
    end else if (cmd.row_wr) begin
      adj_vld_r[in_vertex] <= 1'b1;
    end
  end

  // Stack: save what is left at this depth, reload after a pop
  always_ff @(posedge clk) begin
    if (cmd.expand) stk_r[cs_r] <= p_rest;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r <= in_candidates;
    end else if (cmd.load) begin
      p_r <= stk_r[cs_r];
    end else if (cmd.expand) begin
      p_r <= descend ? next_cand : p_rest;
    end
  end

  // Depth and best size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r   <= '0;
      best_r <= '0;
    end else if (cmd.start) begin
      cs_r   <= '0;
      best_r <= '0;
    end else if (cmd.pop) begin
      cs_r <= cs_r - 1'b1;
    end else if (cmd.expand) begin
      if (deeper > best_r) best_r <= deeper;
      if (descend)         cs_r   <= deeper[VTX_W-1:0];
    end
  end

  // Hold the result for the output channel
  always_ff @(posedge clk) begin
    if (cmd.out_load) size_r <= best_r;
  end

  assign out_clique_size = size_r;

endmodule

// File: hdl/max_clique_size_search.sv
// Channel  Ports                                              Handshake
// in       in_vertex, in_neighbours, in_candidates, in_last   in_valid / in_stall
// out      out_clique_size                                    out_valid / out_stall
//
// A row word without last writes its row and the block stays idle. A last word
// writes its row and starts a depth-first search: a bound test at each node, a
// branch on the lowest candidate, a stack reload after a backtrack, then a hand-off of the size.
// The search tree, walked through the single candidate-stack port, sets the time.
// Synchronous active-low reset clears the row valid bits, depth and best size.
// Input is stalled for the whole search; a stalled result holds in its register.
`include "max_clique_size_search_assert.svh"

module max_clique_size_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mcss_pkg::VTX_W-1:0]  in_vertex,
  input  logic [mcss_pkg::MASK_W-1:0] in_neighbours,
  input  logic [mcss_pkg::MASK_W-1:0] in_candidates,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcss_pkg::SIZE_W-1:0] out_clique_size
);
  import mcss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mcss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcss_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_vertex       (in_vertex),
    .in_neighbours   (in_neighbours),
    .in_candidates   (in_candidates),
    .out_clique_size (out_clique_size)
  );

  // Checks
  `MCSS_ASSERT_NEXT(a_start_blocks, in_valid && !in_stall && in_last, in_stall, "search start did not stall input")
  `MCSS_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not presented")
  `MCSS_ASSERT_NEVER(a_no_expand_idle, (cmd.expand || cmd.pop) && !in_stall, "search step while input open")

endmodule
